### src/ciir_pkg.sv
`timescale 1ns / 1ps
// Package for the complex direct form I IIR filter.
// Holds sizing constants, payload structs, operation codes and state encoding.
// No dependencies.
package ciir_pkg;

	localparam int MAX_FF_TAPS = 16;
	localparam int MAX_FB_TAPS = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int COEF_FRAC   = COEF_BITS - 4;

	localparam int MAX_TAPS    = (MAX_FF_TAPS > MAX_FB_TAPS) ? MAX_FF_TAPS : MAX_FB_TAPS;
	localparam int IDX_BITS    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_BITS    = $clog2(MAX_TAPS + 1);
	localparam int CFG_BITS    = 5;
	localparam int TAP_IDX_BITS = 4;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS    = PROD_BITS + 2 + $clog2(MAX_FF_TAPS + MAX_FB_TAPS);
	localparam int SH_BITS     = ACC_BITS - COEF_FRAC;

	localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'd1 << (COEF_FRAC - 1));
	localparam logic signed [SH_BITS-1:0]  SAT_HI     = SH_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [SH_BITS-1:0]  SAT_LO     = -SAT_HI - SH_BITS'(1);

	localparam logic REG_FF_TAPS = 1'b0;
	localparam logic REG_FB_TAPS = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD_FF   = 2'd0,
		OP_LOAD_FB   = 2'd1,
		OP_LOAD_INIT = 2'd2,
		OP_SAMPLE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FF,
		ST_FB,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                           operation;
		logic [TAP_IDX_BITS-1:0]       tap_index;
		logic signed [SAMPLE_BITS-1:0] value_real;
		logic signed [SAMPLE_BITS-1:0] value_imag;
		logic                          block_start;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_real;
		logic signed [SAMPLE_BITS-1:0] out_imag;
		logic                          clipped;
	} rsp_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} smp_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] re;
		logic signed [COEF_BITS-1:0] im;
	} coef_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] val;
		logic                          clip;
	} sat_t;

	function automatic sat_t round_sat(input logic signed [ACC_BITS-1:0] acc);
		logic signed [ACC_BITS-1:0] t;
		logic signed [SH_BITS-1:0]  sh;
		sat_t                       r;
		t = acc + ROUND_HALF;
		sh = SH_BITS'(t >>> COEF_FRAC);
		if (sh > SAT_HI) begin
			r.val = SAMPLE_BITS'(SAT_HI);
			r.clip = 1'b1;
		end else if (sh < SAT_LO) begin
			r.val = SAMPLE_BITS'(SAT_LO);
			r.clip = 1'b1;
		end else begin
			r.val = SAMPLE_BITS'(sh);
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

### src/complex_iir_difference_equation.sv
`timescale 1ns / 1ps
// Complex direct form I IIR filter, top level.
// Uses ciir_pkg for types, constants and rounding.
//
// Usage:
// - req channel (req_valid/req_ready/req) carries load and sample items.
//   Loads write B[k], A[k] or the initial output y[-(k+1)] and give
//   no result.
// - A sample runs one shared complex multiply-accumulate over the active
//   forward taps, then the active feedback taps, one tap per cycle.
//   The rounded, saturated result is registered onto rsp
//   (rsp_valid/rsp_ready/rsp) after the drain and done states; the next
//   item is not taken until that result has been registered.
// - block_start on a sample clears the input history and reloads the
//   output history from the initial-output store before filtering.
// - cfg_we/cfg_index/cfg_data write the tap counts; write only while idle.
// - Reset (arst_n low) clears coefficients, stores, histories, tap counts
//   (forward 1, feedback 0) and rsp_valid; the rsp data register is not reset.
// - If rsp stalls, the finished sample waits in the done state until the
//   output register frees, and req_ready stays low.
module complex_iir_difference_equation
	import ciir_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                req_valid,
	output logic                req_ready,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output rsp_t                rsp
);

	state_t state_q, state_d;

	logic [CFG_BITS-1:0] ff_taps_q, fb_taps_q;
	logic [CNT_BITS-1:0] nf_q, nb_q, nf_c, nb_c;
	logic [IDX_BITS-1:0] tap_q, tap_d;

	coef_t ff_coef_q [MAX_FF_TAPS];
	coef_t fb_coef_q [MAX_FB_TAPS];
	smp_t  init_q    [MAX_FB_TAPS];
	smp_t  x_hist_q  [MAX_FF_TAPS];
	smp_t  y_hist_q  [MAX_FB_TAPS];

	logic signed [PROD_BITS-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic                        p_valid_s1;
	logic signed [ACC_BITS-1:0]  acc_re_q, acc_im_q;

	coef_t op_c;
	smp_t  op_d;
	sat_t  sat_re, sat_im;

	logic req_xfer, sample_xfer, rsp_load, last_ff, last_fb;
	logic [IDX_BITS-1:0] load_idx;
	smp_t req_smp;
	coef_t req_coef;

	assign req_ready   = (state_q == ST_IDLE);
	assign req_xfer    = req_valid && req_ready;
	assign sample_xfer = req_xfer && (req.operation == OP_SAMPLE);
	assign rsp_load    = (state_q == ST_DONE) && (!rsp_valid || rsp_ready);
	assign load_idx    = IDX_BITS'(req.tap_index);
	assign req_smp     = '{re: req.value_real, im: req.value_imag};
	assign req_coef    = '{re: COEF_BITS'(req.value_real), im: COEF_BITS'(req.value_imag)};

	assign nf_c = (ff_taps_q > CFG_BITS'(MAX_FF_TAPS)) ? CNT_BITS'(MAX_FF_TAPS) : CNT_BITS'(ff_taps_q);
	assign nb_c = (fb_taps_q > CFG_BITS'(MAX_FB_TAPS)) ? CNT_BITS'(MAX_FB_TAPS) : CNT_BITS'(fb_taps_q);

	assign last_ff = (CNT_BITS'(tap_q) == nf_q - CNT_BITS'(1));
	assign last_fb = (CNT_BITS'(tap_q) == nb_q - CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		tap_d = tap_q;
		case (state_q)
			ST_IDLE: begin
				tap_d = '0;
				if (sample_xfer) begin
					if (nf_c != '0) begin
						state_d = ST_FF;
					end else if (nb_c != '0) begin
						state_d = ST_FB;
					end else begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_FF: begin
				tap_d = tap_q + IDX_BITS'(1);
				if (last_ff) begin
					tap_d = '0;
					state_d = (nb_q != '0) ? ST_FB : ST_DRAIN;
				end
			end
			ST_FB: begin
				tap_d = tap_q + IDX_BITS'(1);
				if (last_fb) begin
					tap_d = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_taps_q <= CFG_BITS'(1);
			fb_taps_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FF_TAPS: ff_taps_q <= cfg_data;
				REG_FB_TAPS: fb_taps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			nf_q <= '0;
			nb_q <= '0;
		end else begin
			tap_q <= tap_d;
			if (sample_xfer) begin
				nf_q <= nf_c;
				nb_q <= nb_c;
			end
		end
	end

	// coefficient and initial-output stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FF_TAPS; i++) begin
				ff_coef_q[i] <= '0;
			end
			for (int i = 0; i < MAX_FB_TAPS; i++) begin
				fb_coef_q[i] <= '0;
				init_q[i] <= '0;
			end
		end else if (req_xfer) begin
			case (req.operation)
				OP_LOAD_FF: begin
					if (32'(req.tap_index) < MAX_FF_TAPS) begin
						ff_coef_q[load_idx] <= req_coef;
					end
				end
				OP_LOAD_FB: begin
					if (32'(req.tap_index) < MAX_FB_TAPS) begin
						fb_coef_q[load_idx] <= req_coef;
					end
				end
				OP_LOAD_INIT: begin
					if (32'(req.tap_index) < MAX_FB_TAPS) begin
						init_q[load_idx] <= req_smp;
					end
				end
				default: ;
			endcase
		end
	end

	// input history: x[n] at entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FF_TAPS; i++) begin
				x_hist_q[i] <= '0;
			end
		end else if (sample_xfer) begin
			x_hist_q[0] <= req_smp;
			for (int i = 1; i < MAX_FF_TAPS; i++) begin
				x_hist_q[i] <= req.block_start ? '0 : x_hist_q[i-1];
			end
		end
	end

	// output history: y[n-1] at entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FB_TAPS; i++) begin
				y_hist_q[i] <= '0;
			end
		end else if (sample_xfer && req.block_start) begin
			for (int i = 0; i < MAX_FB_TAPS; i++) begin
				y_hist_q[i] <= init_q[i];
			end
		end else if (rsp_load) begin
			y_hist_q[0] <= '{re: sat_re.val, im: sat_im.val};
			for (int i = 1; i < MAX_FB_TAPS; i++) begin
				y_hist_q[i] <= y_hist_q[i-1];
			end
		end
	end

	// shared complex MAC: multiply stage, then accumulate stage
	always_comb begin
		if (state_q == ST_FB) begin
			op_c = fb_coef_q[tap_q];
			op_d = y_hist_q[tap_q];
		end else begin
			op_c = ff_coef_q[tap_q];
			op_d = x_hist_q[tap_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_valid_s1 <= 1'b0;
		end else begin
			p_valid_s1 <= (state_q == ST_FF) || (state_q == ST_FB);
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= op_c.re * op_d.re;
		p_ii_s1 <= op_c.im * op_d.im;
		p_ri_s1 <= op_c.re * op_d.im;
		p_ir_s1 <= op_c.im * op_d.re;
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (p_valid_s1) begin
			acc_re_q <= acc_re_q + ACC_BITS'(p_rr_s1) - ACC_BITS'(p_ii_s1);
			acc_im_q <= acc_im_q + ACC_BITS'(p_ri_s1) + ACC_BITS'(p_ir_s1);
		end
	end

	assign sat_re = round_sat(acc_re_q);
	assign sat_im = round_sat(acc_im_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp <= '{out_real: sat_re.val, out_imag: sat_im.val,
				clipped: sat_re.clip | sat_im.clip};
		end
	end

endmodule

### src/ciir_checker.sv
`timescale 1ns / 1ps
// Port-level checker for complex_iir_difference_equation, with its bind.
// Uses ciir_pkg for the request type and operation codes.
module ciir_checker
	import ciir_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.operation != OP_SAMPLE) |=> req_ready)
		else $error("load transfer left block busy");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.operation == OP_SAMPLE) |=> !req_ready)
		else $error("sample transfer did not start processing");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared without a sample in flight");

endmodule

bind complex_iir_difference_equation ciir_checker u_ciir_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
